>>> src/ngbs_pkg.sv
// shared constants, types and codes of the normal gap batch statistics block
package ngbs_pkg;

    localparam int GAP_W     = 32;
    localparam int POS_W     = 32;
    localparam int TAG_W     = 32;
    localparam int MAX_ITEMS = 65536;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W     = 48;
    localparam int DEN_W     = CNT_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam int IN_DATA_W   = GAP_W + 3 * POS_W + TAG_W;
    localparam int OUT_FIELD_W = 5 * GAP_W + 2 * CNT_W + 3 * POS_W + TAG_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ITEMS);

    localparam logic [GAP_W-1:0] GAP_MAX = {1'b0, {(GAP_W - 1){1'b1}}};
    localparam logic [GAP_W-1:0] GAP_MIN = {1'b1, {(GAP_W - 1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        SEL_ALL = 2'd0,
        SEL_NEG = 2'd1,
        SEL_POS = 2'd2
    } t_mean_sel;

    typedef struct packed {
        logic      acc_en;
        logic      close;
        logic      div_start;
        t_mean_sel sel;
        logic      quo_store;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> src/ngbs_div.sv
// restoring unsigned divider, one quotient bit per cycle
module ngbs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ngbs_pkg::SUM_W-1:0]  i_dividend,
    input  logic [ngbs_pkg::DEN_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ngbs_pkg::SUM_W-1:0]  o_quotient
);

    localparam logic [ngbs_pkg::DIV_CNT_W-1:0] LAST_STEP =
        ngbs_pkg::DIV_CNT_W'(ngbs_pkg::SUM_W - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [ngbs_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [ngbs_pkg::DEN_W-1:0]      r_rem;
    logic [ngbs_pkg::DEN_W-1:0]      r_den;
    logic [ngbs_pkg::SUM_W-1:0]      r_quo;

    logic [ngbs_pkg::DEN_W:0]        shifted;
    logic                            fits;
    logic [ngbs_pkg::DEN_W:0]        diff;

    assign shifted = {r_rem, r_quo[ngbs_pkg::SUM_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[ngbs_pkg::DEN_W-1:0] : shifted[ngbs_pkg::DEN_W-1:0];
            r_quo <= {r_quo[ngbs_pkg::SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/ngbs_dp.sv
// accumulators, batch snapshot, mean conversion and output register
module ngbs_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ngbs_pkg::t_dp_cmd              i_cmd,
    output ngbs_pkg::t_dp_sts              o_sts,
    input  logic [ngbs_pkg::IN_DATA_W-1:0] i_data,
    input  logic                           i_carries,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [ngbs_pkg::OUT_DATA_W-1:0] o_out_data
);

    localparam int GW = ngbs_pkg::GAP_W;
    localparam int PW = ngbs_pkg::POS_W;
    localparam int SW = ngbs_pkg::SUM_W;
    localparam int CW = ngbs_pkg::CNT_W;

    localparam logic [SW:0] Q_HI = {{(SW + 1 - GW){1'b0}}, ngbs_pkg::GAP_MAX};
    localparam logic [SW:0] Q_LO = {{(SW + 1 - GW){1'b1}}, ngbs_pkg::GAP_MIN};

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
                                              input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1]) begin
            return s[SW] ? ngbs_pkg::SUM_MIN : ngbs_pkg::SUM_MAX;
        end
        return s[SW-1:0];
    endfunction

    // input word fields
    logic [GW-1:0] gap;
    logic [PW-1:0] pos_x, pos_y, pos_z;
    logic [ngbs_pkg::TAG_W-1:0] tag;

    assign gap   = i_data[GW-1:0];
    assign pos_x = i_data[GW +: PW];
    assign pos_y = i_data[GW + PW +: PW];
    assign pos_z = i_data[GW + 2 * PW +: PW];
    assign tag   = i_data[GW + 3 * PW +: ngbs_pkg::TAG_W];

    // running state
    logic [SW-1:0] r_sum_all, r_sum_neg, r_sum_pos;
    logic [SW-1:0] n_sum_all, n_sum_neg, n_sum_pos;
    logic [CW-1:0] r_cnt_neg, r_cnt_pos, n_cnt_neg, n_cnt_pos;
    logic [GW-1:0] r_min, r_max, n_min, n_max;
    logic [PW-1:0] r_px, r_py, r_pz, n_px, n_py, n_pz;

    logic [SW-1:0] gap_ext;
    logic          is_neg;

    assign gap_ext = {{(SW - GW){gap[GW-1]}}, gap};
    assign is_neg  = gap[GW-1];

    always_comb begin
        n_sum_all = r_sum_all;
        n_sum_neg = r_sum_neg;
        n_sum_pos = r_sum_pos;
        n_cnt_neg = r_cnt_neg;
        n_cnt_pos = r_cnt_pos;
        n_min     = r_min;
        n_max     = r_max;
        n_px      = r_px;
        n_py      = r_py;
        n_pz      = r_pz;
        if (i_cmd.acc_en && i_carries) begin
            // a class already at its limit is left out of count and sums
            if (is_neg) begin
                if (r_cnt_neg < ngbs_pkg::CNT_LIMIT) begin
                    n_cnt_neg = r_cnt_neg + 1'b1;
                    n_sum_neg = sat_add(r_sum_neg, gap_ext);
                    n_sum_all = sat_add(r_sum_all, gap_ext);
                end
            end else begin
                if (r_cnt_pos < ngbs_pkg::CNT_LIMIT) begin
                    n_cnt_pos = r_cnt_pos + 1'b1;
                    n_sum_pos = sat_add(r_sum_pos, gap_ext);
                    n_sum_all = sat_add(r_sum_all, gap_ext);
                end
            end
            if ($signed(gap) < $signed(r_min)) begin
                n_min = gap;
                n_px  = pos_x;
                n_py  = pos_y;
                n_pz  = pos_z;
            end
            if ($signed(gap) > $signed(r_max)) begin
                n_max = gap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.close) begin
            r_sum_all <= '0;
            r_sum_neg <= '0;
            r_sum_pos <= '0;
            r_cnt_neg <= '0;
            r_cnt_pos <= '0;
            r_min     <= ngbs_pkg::GAP_MAX;
            r_max     <= ngbs_pkg::GAP_MIN;
            r_px      <= '0;
            r_py      <= '0;
            r_pz      <= '0;
        end else begin
            r_sum_all <= n_sum_all;
            r_sum_neg <= n_sum_neg;
            r_sum_pos <= n_sum_pos;
            r_cnt_neg <= n_cnt_neg;
            r_cnt_pos <= n_cnt_pos;
            r_min     <= n_min;
            r_max     <= n_max;
            r_px      <= n_px;
            r_py      <= n_py;
            r_pz      <= n_pz;
        end
    end

    // snapshot of the closed batch
    logic [SW-1:0] r_s_sum_all, r_s_sum_neg, r_s_sum_pos;
    logic [CW-1:0] r_s_cnt_neg, r_s_cnt_pos;
    logic [GW-1:0] r_s_min, r_s_max;
    logic [PW-1:0] r_s_px, r_s_py, r_s_pz;
    logic [ngbs_pkg::TAG_W-1:0] r_s_tag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.close) begin
            r_s_sum_all <= n_sum_all;
            r_s_sum_neg <= n_sum_neg;
            r_s_sum_pos <= n_sum_pos;
            r_s_cnt_neg <= n_cnt_neg;
            r_s_cnt_pos <= n_cnt_pos;
            r_s_min     <= n_min;
            r_s_max     <= n_max;
            r_s_px      <= n_px;
            r_s_py      <= n_py;
            r_s_pz      <= n_pz;
            r_s_tag     <= tag;
        end
    end

    // operand selection for the shared divider
    logic [SW-1:0]              sel_sum;
    logic [ngbs_pkg::DEN_W-1:0] sel_den;
    logic [SW-1:0]              dividend;
    logic                       div_done;
    logic [SW-1:0]              quotient;

    always_comb begin
        case (i_cmd.sel)
            ngbs_pkg::SEL_ALL: begin
                sel_sum = r_s_sum_all;
                sel_den = {1'b0, r_s_cnt_neg} + {1'b0, r_s_cnt_pos};
            end
            ngbs_pkg::SEL_NEG: begin
                sel_sum = r_s_sum_neg;
                sel_den = {1'b0, r_s_cnt_neg};
            end
            ngbs_pkg::SEL_POS: begin
                sel_sum = r_s_sum_pos;
                sel_den = {1'b0, r_s_cnt_pos};
            end
            default: begin
                sel_sum = '0;
                sel_den = '0;
            end
        endcase
    end

    // magnitude of the sum, the most negative sum wraps to its own magnitude
    assign dividend = sel_sum[SW-1] ? (~sel_sum + 1'b1) : sel_sum;

    ngbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (sel_den),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // signed quotient, truncated toward zero, clamped to the gap range
    logic [SW:0]   q_signed;
    logic [GW-1:0] mean_val;

    assign q_signed = sel_sum[SW-1] ? (~{1'b0, quotient} + 1'b1) : {1'b0, quotient};

    always_comb begin
        if (sel_den == '0) begin
            mean_val = '0;
        end else if ($signed(q_signed) > $signed(Q_HI)) begin
            mean_val = ngbs_pkg::GAP_MAX;
        end else if ($signed(q_signed) < $signed(Q_LO)) begin
            mean_val = ngbs_pkg::GAP_MIN;
        end else begin
            mean_val = q_signed[GW-1:0];
        end
    end

    logic [GW-1:0] r_mean_all, r_mean_neg, r_mean_pos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.quo_store) begin
            case (i_cmd.sel)
                ngbs_pkg::SEL_ALL: r_mean_all <= mean_val;
                ngbs_pkg::SEL_NEG: r_mean_neg <= mean_val;
                ngbs_pkg::SEL_POS: r_mean_pos <= mean_val;
                default:           r_mean_all <= r_mean_all;
            endcase
        end
    end

    // output register
    logic                           r_out_valid;
    logic [ngbs_pkg::OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {{(ngbs_pkg::OUT_DATA_W - ngbs_pkg::OUT_FIELD_W){1'b0}},
                           r_s_tag, r_s_pz, r_s_py, r_s_px,
                           r_s_cnt_pos, r_s_cnt_neg,
                           r_mean_pos, r_mean_neg, r_mean_all,
                           r_s_max, r_s_min};
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

>>> src/ngbs_ctrl.sv
// batch controller: accumulate, three divisions, result hand-off
module ngbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  ngbs_pkg::t_dp_sts i_sts,
    output ngbs_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_ACC   = 4'b0001,
        ST_START = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_LOAD  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    ngbs_pkg::t_mean_sel r_sel, n_sel;
    logic                accept;

    assign o_in_ready = (r_state == ST_ACC);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state         = r_state;
        n_sel           = r_sel;
        o_cmd.acc_en    = accept;
        o_cmd.close     = accept && i_in_last;
        o_cmd.div_start = 1'b0;
        o_cmd.sel       = r_sel;
        o_cmd.quo_store = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_ACC: begin
                if (accept && i_in_last) begin
                    n_state = ST_START;
                    n_sel   = ngbs_pkg::SEL_ALL;
                end
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_RUN;
            end
            ST_RUN: begin
                if (i_sts.div_done) begin
                    o_cmd.quo_store = 1'b1;
                    case (r_sel)
                        ngbs_pkg::SEL_ALL: begin
                            n_sel   = ngbs_pkg::SEL_NEG;
                            n_state = ST_START;
                        end
                        ngbs_pkg::SEL_NEG: begin
                            n_sel   = ngbs_pkg::SEL_POS;
                            n_state = ST_START;
                        end
                        default: begin
                            n_state = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_sel   <= ngbs_pkg::SEL_ALL;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

>>> src/normal_gap_batch_statistics.sv
// normal gap batch statistics: top level, stream ports, controller and datapath
//
// Collects per-batch statistics of contact gaps (signed Q8.24) with their Q16.16
// positions. Every input word with tuser set adds one gap: the minimum (first
// position kept on ties), the maximum, the total sum and the separate sums and
// counts of negative and non-negative gaps (zero is non-negative). Counts stop
// at 65536 per class, and a gap beyond that limit still updates min and max but
// no sum. A word with tlast closes the batch (with or without a gap of its own)
// and yields one result word: min, max, the three means (truncated toward zero,
// zero for an empty class), both counts, the position of the minimum and the
// closing word's time tag. An empty batch gives min as the largest code and max
// as the smallest. Words that do not close a batch are taken back to back. A
// closing word starts three divisions on one shared restoring divider that
// retires one quotient bit per cycle over a 48-bit sum, then the result register
// is loaded; s_axis_tready stays low from a closing word until that load, and
// the load also waits while the previous result still waits on m_axis_tready.
// The result sits in an output register, so a new batch may be collected while
// it waits.
module normal_gap_batch_statistics (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // gap_value, pos_x, pos_y, pos_z, time_tag
    input  logic [ngbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // carries_value
    input  logic                            s_axis_tuser,
    // last_of_batch
    input  logic                            s_axis_tlast,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // gap_min, gap_max, mean_all, mean_neg, mean_pos, count_neg, count_pos,
    // min_pos_x, min_pos_y, min_pos_z, batch_time, zero fill
    output logic [ngbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready
);

    ngbs_pkg::t_dp_cmd cmd;
    ngbs_pkg::t_dp_sts sts;

    // sequencing: accumulate, then mean of all, negative, non-negative, then load
    ngbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // accumulators, snapshot, divider and result register
    ngbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_data      (s_axis_tdata),
        .i_carries   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
